// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the hash table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OAHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hash table assertion failed");
`define OAHT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hash table assertion failed");
`else
`define OAHT_ASSERT(lbl, prop)
`define OAHT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/oaht_pkg.sv =====
// Shared types and constants of the open-addressing hash table.
package oaht_pkg;

  localparam int KEY_W   = 31;
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 10;
  localparam int MOD_W   = 16;
  localparam int TS_W    = 11;
  localparam int MODE_W  = 2;
  localparam int DIV_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int DEPTH_DEF  = 1024;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LINEAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUADRATIC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIMARY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECONDARY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = 2'd3;

  localparam logic [MODE_W-1:0] PROBE_MODE_RST = MODE_DOUBLE;
  localparam logic [MOD_W-1:0]  PRIMARY_RST    = 16'd11;
  localparam logic [MOD_W-1:0]  SECONDARY_RST  = 16'd5;
  localparam logic [TS_W-1:0]   SLOT_LIMIT_RST = 11'd1024;

  // request to the remainder unit
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== hdl/open_addressing_hash_table_core.sv =====
// Open-addressing hash table core: insert, search and delete of 31-bit keys.
// After reset the core sweeps the slot memory, one slot a cycle, through all
// TABLE_DEPTH slots before it takes the first item; write configuration only
// while no transaction is in flight. Each item then runs four divisions in the
// shared bit-serial remainder unit (home hash, home mod size, step hash, step
// mod size), each through the 31 key bits, then a slot memory read and compare
// per probe, then the result register and the idle state, with at most as many
// probes as the effective table size. An unknown command skips the divisions and
// probes and goes straight to the result register with a failure status. One
// item is in work at a time; the result waits in an output register.
module open_addressing_hash_table_core #(
  parameter int TABLE_DEPTH = oaht_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // command [1:0], key [32:2], zero fill above
  input  logic [oaht_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // status [0], slot_index [10:1], zero fill above
  output logic [oaht_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [oaht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [oaht_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import oaht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = AW + 1;
  localparam int CW = (SW > TS_W) ? SW : TS_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HOME, ST_HOMES, ST_STEP, ST_STEPS, ST_RD, ST_CHK, ST_DONE
  } state_t;

  state_t            state;
  logic [MODE_W-1:0] probe_mode;
  logic [MOD_W-1:0]  primary_modulus;
  logic [MOD_W-1:0]  secondary_modulus;
  logic [TS_W-1:0]   slot_limit;

  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     step;
  logic [AW-1:0]     delta;
  logic [SW-1:0]     probe_cnt;
  logic [AW-1:0]     clr_cnt;
  logic              res_fail;
  logic [SLOT_W-1:0] res_slot;
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_W-1:0]  div_rem;

  logic [CW-1:0]     ts_ext;
  logic [SW-1:0]     eff_size;
  logic [AW-1:0]     one_mod;
  logic [AW-1:0]     inc;
  logic [SW-1:0]     pos_sum;
  logic [AW-1:0]     pos_next;
  logic [SW:0]       delta_sum;
  logic [AW-1:0]     delta_next;
  logic [SW-1:0]     cnt_next;
  logic              rd_en;
  logic [KEY_W:0]    rd_data;
  logic              hit;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [KEY_W:0]    wr_data;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  // effective size: zero acts as one, clamp to the depth
  assign ts_ext   = CW'(slot_limit);
  assign eff_size = (ts_ext == '0) ? SW'(1) :
                    (ts_ext > CW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : SW'(ts_ext);
  assign one_mod  = (eff_size == SW'(1)) ? '0 : AW'(1);

  // probe advance per mode
  always_comb begin
    case (probe_mode)
      MODE_QUADRATIC: inc = delta;
      MODE_DOUBLE:    inc = step;
      default:        inc = one_mod;
    endcase
  end

  assign pos_sum   = {1'b0, pos} + {1'b0, inc};
  assign pos_next  = (pos_sum >= eff_size) ? AW'(pos_sum - eff_size) : AW'(pos_sum);
  assign delta_sum = (SW+1)'(delta) + (SW+1)'(2);
  always_comb begin
    if (delta_sum >= {eff_size, 1'b0}) begin
      delta_next = AW'(delta_sum - {eff_size, 1'b0});
    end else if (delta_sum >= {1'b0, eff_size}) begin
      delta_next = AW'(delta_sum - {1'b0, eff_size});
    end else begin
      delta_next = AW'(delta_sum);
    end
  end
  assign cnt_next = SW'(probe_cnt + 1'b1);

  // slot check and memory write selection
  assign rd_en = (state == ST_RD);
  assign hit   = (cmd == CMD_INSERT) ? !rd_data[KEY_W]
                                     : (rd_data[KEY_W] && rd_data[KEY_W-1:0] == key);
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
    end else if (state == ST_CHK && hit && cmd != CMD_SEARCH) begin
      wr_en   = 1'b1;
      wr_data = (cmd == CMD_INSERT) ? {1'b1, key} : '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode        <= PROBE_MODE_RST;
      primary_modulus   <= PRIMARY_RST;
      secondary_modulus <= SECONDARY_RST;
      slot_limit        <= SLOT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROBE_MODE: probe_mode        <= cfg_data[MODE_W-1:0];
        REG_PRIMARY:    primary_modulus   <= cfg_data[MOD_W-1:0];
        REG_SECONDARY:  secondary_modulus <= cfg_data[MOD_W-1:0];
        REG_SLOT_LIMIT: slot_limit        <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // operation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      div_req.start <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      // drop the result once taken, unless a new one is loaded this cycle
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd <= s_axis_tdata[CMD_W-1:0];
            key <= s_axis_tdata[CMD_W +: KEY_W];
            if (s_axis_tdata[CMD_W-1:0] == CMD_INSERT ||
                s_axis_tdata[CMD_W-1:0] == CMD_SEARCH ||
                s_axis_tdata[CMD_W-1:0] == CMD_DELETE) begin
              div_req.start    <= 1'b1;
              div_req.dividend <= s_axis_tdata[CMD_W +: KEY_W];
              div_req.divisor  <= DIV_W'(primary_modulus);
              state            <= ST_HOME;
            end else begin
              res_fail <= 1'b1;
              res_slot <= '0;
              state    <= ST_DONE;
            end
          end
        end
        ST_HOME: begin
          if (div_done) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= (primary_modulus == '0) ? '0 : KEY_W'(div_rem);
            div_req.divisor  <= DIV_W'(eff_size);
            state            <= ST_HOMES;
          end
        end
        ST_HOMES: begin
          if (div_done) begin
            pos              <= div_rem[AW-1:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= key;
            div_req.divisor  <= DIV_W'(secondary_modulus);
            state            <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (div_done) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= (secondary_modulus == '0) ? '0 : KEY_W'(div_rem);
            div_req.divisor  <= DIV_W'(eff_size);
            state            <= ST_STEPS;
          end
        end
        ST_STEPS: begin
          if (div_done) begin
            step      <= div_rem[AW-1:0];
            delta     <= one_mod;
            probe_cnt <= '0;
            state     <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (hit) begin
            res_fail <= 1'b0;
            res_slot <= SLOT_W'(pos);
            state    <= ST_DONE;
          end else if (cnt_next == eff_size) begin
            res_fail <= 1'b1;
            res_slot <= '0;
            state    <= ST_DONE;
          end else begin
            probe_cnt <= cnt_next;
            pos       <= pos_next;
            delta     <= delta_next;
            state     <= ST_RD;
          end
        end
        ST_DONE: begin
          // hand over once the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_DATA_W'({res_slot, res_fail});
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  oaht_rem u_rem (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .rem  (div_rem)
  );

  oaht_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (pos),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

`include "assert_macros.svh"

  `OAHT_ASSERT(a_probe_in_range, (state == ST_RD) |-> ({1'b0, pos} < eff_size))
  `OAHT_ASSERT(a_count_in_range, (state == ST_CHK) |-> (probe_cnt < eff_size))
  `OAHT_ASSERT(a_fail_slot_zero, (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[10:1] == '0))
  `OAHT_ASSERT_ALWAYS(a_no_accept_in_reset, rst |=> !s_axis_tready)

endmodule

// ===== hdl/oaht_rem.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module oaht_rem (
  input  logic                    clk,
  input  logic                    rst,
  input  oaht_pkg::div_req_t      req,
  output logic                    done,
  output logic [oaht_pkg::DIV_W-1:0] rem
);
  import oaht_pkg::*;

  localparam int CNT_W = $clog2(KEY_W + 1);

  logic [KEY_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIV_W:0]   trial;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, quo[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(KEY_W);
        quo  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        quo <= {quo[KEY_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
          rem <= DIV_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[DIV_W-1:0];
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/oaht_mem.sv =====
// Slot store: one word per slot, occupied flag over the key, registered read.
module oaht_mem #(
  parameter int DEPTH = oaht_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [oaht_pkg::KEY_W:0] rd_data,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [oaht_pkg::KEY_W:0] wr_data
);
  import oaht_pkg::*;

  logic [KEY_W:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ram[rd_addr];
    end
  end

endmodule
